[src/fmpc_pkg.sv]
`timescale 1ns / 1ps

package fmpc_pkg;

    localparam int SLOT_W    = 4;
    localparam int PORT_W    = 16;
    localparam int LABEL_W   = 8;
    localparam int COUNT_W   = 5;
    localparam int MAX_SLOTS = 16;

    typedef enum logic
    {
        REQ_CLASSIFY = 1'b0,
        REQ_WRITE    = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        logic              proto;
        logic [PORT_W-1:0] src;
        logic [PORT_W-1:0] dst;
    } key_t;

    typedef struct packed
    {
        logic               proto;
        logic [PORT_W-1:0]  src;
        logic [PORT_W-1:0]  dst;
        logic [LABEL_W-1:0] label;
    } rule_t;

    typedef struct packed
    {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        rule_t             wr_rule;
    } table_wr_t;

endpackage

[src/fmpc_if.sv]
`timescale 1ns / 1ps

interface fmpc_req_if;
    import fmpc_pkg::*;

    logic               valid;
    logic               ready;
    req_kind_t          req_type;
    logic [SLOT_W-1:0]  rule_slot;
    logic               protocol;
    logic [PORT_W-1:0]  source_port;
    logic [PORT_W-1:0]  dest_port;
    logic [LABEL_W-1:0] rule_label;

    modport source
    (
        output valid, req_type, rule_slot, protocol, source_port, dest_port, rule_label,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, rule_slot, protocol, source_port, dest_port, rule_label,
        output ready
    );
endinterface

interface fmpc_res_if;
    import fmpc_pkg::*;

    logic               valid;
    logic               ready;
    logic               matched;
    logic [SLOT_W-1:0]  match_index;
    logic [LABEL_W-1:0] match_label;

    modport source
    (
        output valid, matched, match_index, match_label,
        input  ready
    );

    modport sink
    (
        input  valid, matched, match_index, match_label,
        output ready
    );
endinterface

interface fmpc_cfg_if;
    import fmpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] rule_count;

    modport source
    (
        output valid, rule_count,
        input  ready
    );

    modport sink
    (
        input  valid, rule_count,
        output ready
    );
endinterface

[src/first_match_port_classifier_top.sv]
`timescale 1ns / 1ps

// First-match port classifier.
// The req channel carries one word per request. A write word stores one rule
// (protocol, source port, destination port, label) into a slot and gives no
// result. A classify word gives exactly one result word on the res channel:
// the lowest-indexed rule in use whose protocol matches and whose ports are
// zero or equal to the packet's ports, or a word with matched low and zeros.
// The cfg channel sets the number of slots in use; it is always ready.
// A result passes through the three-stage match pipeline after its request is
// accepted, and one word can be accepted in every cycle while the pipeline is not held.
// When the receiver holds res.ready low with a result waiting, the whole
// pipeline freezes and req.ready falls until the result is taken.
// Reset empties the pipeline and clears the rule count to zero. Table entries
// are undefined until written and must be written before they are in use.
module first_match_port_classifier_top #(
    parameter int RULES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    fmpc_req_if.sink   req,
    fmpc_res_if.source res,
    fmpc_cfg_if.sink   cfg
);
    import fmpc_pkg::*;

    localparam int DEPTH = (RULES < MAX_SLOTS) ? RULES : MAX_SLOTS;

    logic [COUNT_W-1:0] rule_count_reg;
    logic               advance;
    logic               accept;
    table_wr_t          wr;
    key_t               key;
    logic [DEPTH-1:0]   hit;
    logic [DEPTH-1:0]   first;
    logic [LABEL_W-1:0] first_label;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            rule_count_reg <= cfg.rule_count;
        end
    end

    assign req.ready = advance;
    assign accept    = req.valid && advance;

    assign wr.wr_en         = accept && (req.req_type == REQ_WRITE);
    assign wr.wr_slot       = req.rule_slot;
    assign wr.wr_rule.proto = req.protocol;
    assign wr.wr_rule.src   = req.source_port;
    assign wr.wr_rule.dst   = req.dest_port;
    assign wr.wr_rule.label = req.rule_label;

    assign key.proto = req.protocol;
    assign key.src   = req.source_port;
    assign key.dst   = req.dest_port;

    fmpc_rule_table #(
        .DEPTH(DEPTH)
    ) u_table (
        .clk        (clk),
        .wr         (wr),
        .rule_count (rule_count_reg),
        .key        (key),
        .hit        (hit),
        .sel        (first),
        .sel_label  (first_label)
    );

    fmpc_match_pipe #(
        .DEPTH(DEPTH)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (accept && (req.req_type == REQ_CLASSIFY)),
        .hit         (hit),
        .first       (first),
        .first_label (first_label),
        .res         (res)
    );

endmodule

[src/fmpc_rule_table.sv]
`timescale 1ns / 1ps

module fmpc_rule_table #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  fmpc_pkg::table_wr_t         wr,
    input  logic [fmpc_pkg::COUNT_W-1:0] rule_count,
    input  fmpc_pkg::key_t              key,
    output logic [DEPTH-1:0]            hit,
    input  logic [DEPTH-1:0]            sel,
    output logic [fmpc_pkg::LABEL_W-1:0] sel_label
);
    import fmpc_pkg::*;

    rule_t rules_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (wr.wr_en && (wr.wr_slot == SLOT_W'(i)))
            begin
                rules_reg[i] <= wr.wr_rule;
            end
        end
    end

    // Each lane checks its own rule; lanes at or above the rule count are masked.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit[i] = (COUNT_W'(i) < rule_count)
                  && (rules_reg[i].proto == key.proto)
                  && ((rules_reg[i].src == '0) || (rules_reg[i].src == key.src))
                  && ((rules_reg[i].dst == '0) || (rules_reg[i].dst == key.dst));
        end
    end

    always_comb
    begin
        sel_label = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_label = sel_label | (sel[i] ? rules_reg[i].label : LABEL_W'(0));
        end
    end

endmodule

[src/fmpc_match_pipe.sv]
`timescale 1ns / 1ps

module fmpc_match_pipe #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         advance,
    input  logic                         in_valid,
    input  logic [DEPTH-1:0]             hit,
    output logic [DEPTH-1:0]             first,
    input  logic [fmpc_pkg::LABEL_W-1:0] first_label,
    fmpc_res_if.source                   res
);
    import fmpc_pkg::*;

    logic               s1_valid_reg;
    logic [DEPTH-1:0]   s1_hit_reg;
    logic               s2_valid_reg;
    logic [DEPTH-1:0]   s2_onehot_reg;
    logic [LABEL_W-1:0] s2_label_reg;
    logic               s3_valid_reg;
    logic               s3_matched_reg;
    logic [SLOT_W-1:0]  s3_index_reg;
    logic [LABEL_W-1:0] s3_label_reg;

    logic               s3_matched_next;
    logic [SLOT_W-1:0]  s3_index_next;

    // The whole pipeline moves together; it holds only while the output word waits.
    assign advance = !s3_valid_reg || res.ready;

    // Isolate the lowest set bit, which is the first matching rule.
    assign first = s1_hit_reg & (~s1_hit_reg + DEPTH'(1));

    always_comb
    begin
        s3_matched_next = |s2_onehot_reg;
        s3_index_next   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            s3_index_next = s3_index_next | (s2_onehot_reg[i] ? SLOT_W'(i) : SLOT_W'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_hit_reg     <= hit;
            s2_onehot_reg  <= first;
            s2_label_reg   <= first_label;
            s3_matched_reg <= s3_matched_next;
            s3_index_reg   <= s3_index_next;
            s3_label_reg   <= s2_label_reg;
        end
    end

    assign res.valid       = s3_valid_reg;
    assign res.matched     = s3_matched_reg;
    assign res.match_index = s3_index_reg;
    assign res.match_label = s3_label_reg;

endmodule

[test/first_match_port_classifier_checker.sv]
`timescale 1ns / 1ps

module first_match_port_classifier_checker
(
    input  logic clk,
    input  logic rst_n,
    fmpc_req_if  req,
    fmpc_res_if  res,
    fmpc_cfg_if  cfg,
    output int   fail_count,
    output int   pending,
    output int   writes_seen,
    output int   lookups_seen,
    output int   hits_seen
);
    import fmpc_pkg::*;

    typedef struct packed
    {
        logic               matched;
        logic [SLOT_W-1:0]  index;
        logic [LABEL_W-1:0] label;
    } match_t;

    rule_t              rule_table [MAX_SLOTS];
    logic [COUNT_W-1:0] rules_in_use;
    match_t             expected_matches [$];

    function automatic match_t predict_match(key_t key);
        match_t hit;
        int     limit;
        hit   = '0;
        limit = (rules_in_use > MAX_SLOTS) ? MAX_SLOTS : int'(rules_in_use);
        for (int i = 0; i < limit; i++)
        begin
            if (rule_table[i].proto == key.proto &&
                (rule_table[i].src == '0 || rule_table[i].src == key.src) &&
                (rule_table[i].dst == '0 || rule_table[i].dst == key.dst))
            begin
                hit.matched = 1'b1;
                hit.index   = i[SLOT_W-1:0];
                hit.label   = rule_table[i].label;
                return hit;
            end
        end
        return hit;
    endfunction

    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        key_t   key;
        if (!rst_n)
        begin
            rules_in_use = '0;
            fail_count   = 0;
            pending      = 0;
            writes_seen  = 0;
            lookups_seen = 0;
            hits_seen    = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = '{res.matched, res.match_index, res.match_label};
                if (expected_matches.size() == 0)
                begin
                    $display("%0t: unexpected result word matched=%0d index=%0d label=%0h",
                             $time, got.matched, got.index, got.label);
                    fail_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (got.matched !== want.matched || got.index !== want.index ||
                        got.label !== want.label)
                    begin
                        $display("%0t: expected %0d/%0d/%0h, got %0d/%0d/%0h (matched/index/label)",
                                 $time, want.matched, want.index, want.label,
                                 got.matched, got.index, got.label);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_WRITE)
                begin
                    rule_table[req.rule_slot] = '{req.protocol, req.source_port, req.dest_port,
                                                  req.rule_label};
                    writes_seen++;
                end
                else
                begin
                    key  = '{req.protocol, req.source_port, req.dest_port};
                    want = predict_match(key);
                    expected_matches.push_back(want);
                    lookups_seen++;
                    if (want.matched)
                        hits_seen++;
                end
            end
            if (cfg.valid && cfg.ready)
                rules_in_use = cfg.rule_count;
            pending = expected_matches.size();
        end
    end

endmodule

[test/first_match_port_classifier_top_test.sv]
`timescale 1ns / 1ps

module first_match_port_classifier_top_test;
    import fmpc_pkg::*;

    localparam int   ITEMS_PER_BLOCK  = 150;
    localparam int   BLOCKS           = 12;
    localparam int   BLOCKS_PER_PHASE = 4;
    localparam int   PIPE_LATENCY     = 3;
    localparam int   STALL_LIMIT      = 2000;
    localparam logic PROTO_TCP        = 1'b0;
    localparam logic PROTO_UDP        = 1'b1;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    int    fail_count;
    int    pending;
    int    writes_seen;
    int    lookups_seen;
    int    hits_seen;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    quiet_cycles   = 0;
    int    settings_used  = 0;
    int    phase;
    rule_t rule_shadow [MAX_SLOTS];

    fmpc_req_if req();
    fmpc_res_if res();
    fmpc_cfg_if cfg();

    always #5 clk = ~clk;

    first_match_port_classifier_top #(
        .RULES(MAX_SLOTS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .res  (res),
        .cfg  (cfg)
    );

    first_match_port_classifier_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .cfg         (cfg),
        .fail_count  (fail_count),
        .pending     (pending),
        .writes_seen (writes_seen),
        .lookups_seen(lookups_seen),
        .hits_seen   (hits_seen)
    );

    always @(posedge clk)
    begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("first_match_port_classifier_top_test: FAIL");
            $finish;
        end
    end

    task automatic send_word(req_kind_t kind, logic [SLOT_W-1:0] slot, key_t key,
                             logic [LABEL_W-1:0] label);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= kind;
        req.rule_slot   <= slot;
        req.protocol    <= key.proto;
        req.source_port <= key.src;
        req.dest_port   <= key.dst;
        req.rule_label  <= label;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic write_rule(logic [SLOT_W-1:0] slot, rule_t rule);
        rule_shadow[slot] = rule;
        send_word(REQ_WRITE, slot, '{rule.proto, rule.src, rule.dst}, rule.label);
    endtask

    task automatic classify(key_t key);
        send_word(REQ_CLASSIFY, SLOT_W'($urandom), key, LABEL_W'($urandom));
    endtask

    task automatic set_rule_count(logic [COUNT_W-1:0] count);
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        cfg.valid      <= 1'b1;
        cfg.rule_count <= count;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [PORT_W-1:0] random_port();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return '0;
        if (pick < 50)
        begin
            case ($urandom_range(3))
                0:       return 16'd80;
                1:       return 16'd443;
                2:       return 16'd53;
                default: return 16'hFFFF;
            endcase
        end
        return PORT_W'($urandom);
    endfunction

    function automatic rule_t random_rule();
        rule_t rule;
        rule.proto = 1'($urandom);
        rule.src   = random_port();
        rule.dst   = random_port();
        rule.label = LABEL_W'($urandom);
        return rule;
    endfunction

    function automatic key_t random_packet();
        rule_t target;
        key_t  key;
        int    pick;
        target    = rule_shadow[SLOT_W'($urandom_range(MAX_SLOTS - 1))];
        pick      = $urandom_range(99);
        key.proto = target.proto;
        key.src   = (target.src == '0) ? PORT_W'($urandom) : target.src;
        key.dst   = (target.dst == '0) ? PORT_W'($urandom) : target.dst;
        if (pick >= 85)
        begin
            key.proto = 1'($urandom);
            key.src   = PORT_W'($urandom);
            key.dst   = PORT_W'($urandom);
        end
        else if (pick >= 60)
        begin
            case ($urandom_range(2))
                0:       key.proto = ~key.proto;
                1:       key.src   = key.src ^ PORT_W'($urandom_range(1, 65535));
                default: key.dst   = key.dst ^ PORT_W'($urandom_range(1, 65535));
            endcase
        end
        return key;
    endfunction

    initial
    begin
        req.valid       <= 1'b0;
        req.req_type    <= REQ_CLASSIFY;
        req.rule_slot   <= '0;
        req.protocol    <= PROTO_TCP;
        req.source_port <= '0;
        req.dest_port   <= '0;
        req.rule_label  <= '0;
        cfg.valid       <= 1'b0;
        cfg.rule_count  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        classify('{PROTO_TCP, 16'h0000, 16'h0000});
        classify('{PROTO_UDP, 16'hFFFF, 16'hFFFF});

        write_rule(4'd0, '{PROTO_UDP, 16'hFFFF, 16'hFFFF, 8'hA5});
        write_rule(4'd1, '{PROTO_TCP, 16'd0, 16'd80, 8'h01});
        write_rule(4'd2, '{PROTO_TCP, 16'd1234, 16'd0, 8'h5A});
        write_rule(4'd3, '{PROTO_UDP, 16'd0, 16'd0, 8'hFF});
        set_rule_count(5'd4);
        classify('{PROTO_UDP, 16'hFFFF, 16'hFFFF});
        classify('{PROTO_UDP, 16'd1, 16'd2});
        classify('{PROTO_TCP, 16'd5000, 16'd80});
        classify('{PROTO_TCP, 16'd1234, 16'd443});
        classify('{PROTO_TCP, 16'd1234, 16'd80});
        classify('{PROTO_TCP, 16'h0000, 16'h0000});
        classify('{PROTO_TCP, 16'hFFFF, 16'hFFFF});
        set_rule_count(5'd1);
        classify('{PROTO_UDP, 16'd1, 16'd2});
        classify('{PROTO_UDP, 16'hFFFF, 16'hFFFF});

        for (int i = 0; i < MAX_SLOTS; i++)
            write_rule(SLOT_W'(i), random_rule());

        for (int b = 0; b < BLOCKS; b++)
        begin
            phase          = b / BLOCKS_PER_PHASE;
            send_idle_pct  = (phase == 0) ? 31 : (phase == 1) ? 58 : 0;
            recv_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 31 : 0;
            case (b)
                0:       set_rule_count(COUNT_W'(MAX_SLOTS));
                1:       set_rule_count(5'h1F);
                2:       set_rule_count(5'd0);
                default: set_rule_count(COUNT_W'($urandom_range(1, 31)));
            endcase
            for (int i = 0; i < ITEMS_PER_BLOCK; i++)
            begin
                if ($urandom_range(99) < 12)
                    write_rule(SLOT_W'($urandom_range(MAX_SLOTS - 1)), random_rule());
                else
                    classify(random_packet());
            end
        end

        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (PIPE_LATENCY + 5) @(posedge clk);

        $display("Covered %0d rule writes and %0d lookups (%0d hits) over %0d rule-count settings,",
                 writes_seen, lookups_seen, hits_seen, settings_used);
        $display("with sender/receiver idle mixes of 31/58, 58/31 and none.");
        if (fail_count == 0)
            $display("first_match_port_classifier_top_test: PASS");
        else
            $display("first_match_port_classifier_top_test: FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/fmpc_pkg.sv
src/fmpc_if.sv
src/fmpc_rule_table.sv
src/fmpc_match_pipe.sv
src/first_match_port_classifier_top.sv
test/first_match_port_classifier_checker.sv
test/first_match_port_classifier_top_test.sv
